// ===== hw/rtl/ortp_pkg.sv =====
package ortp_pkg;

   localparam int ONESHOT_DEPTH   = 8;
   localparam int RECURRING_DEPTH = 8;
   localparam int PAYLOAD_BYTES   = 8;

   localparam int OPCODE_W  = 2;
   localparam int ACTION_W  = 8;
   localparam int LENGTH_W  = 4;
   localparam int FIELD_W   = 64;
   localparam int IDX_W     = 3;
   localparam int PAY_W     = 8 * PAYLOAD_BYTES;

   localparam int OS_AW = $clog2(ONESHOT_DEPTH);
   localparam int OS_CW = $clog2(ONESHOT_DEPTH + 1);
   localparam int RC_AW = $clog2(RECURRING_DEPTH);
   localparam int RC_CW = $clog2(RECURRING_DEPTH + 1);
   localparam int CNT_W = (OS_CW > RC_CW) ? OS_CW : RC_CW;
   localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND_ONESHOT   = 2'd0,
      OP_REMOVE_ONESHOT   = 2'd1,
      OP_APPEND_RECURRING = 2'd2,
      OP_PICK             = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_BAD_INDEX = 2'd2,
      STAT_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SHIFT,
      ST_SHIFT_WR,
      ST_PICK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [LENGTH_W-1:0] length;
      logic [PAY_W-1:0]    payload;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic             req_ready;
      logic             rsp_valid;
      logic             os_we;
      logic [OS_AW-1:0] os_waddr;
      logic             os_wsel_shift;
      logic [OS_AW-1:0] os_raddr;
      logic             rc_we;
      logic [RC_AW-1:0] rc_waddr;
      logic [RC_AW-1:0] rc_raddr;
      logic             res_clear;
      logic             res_pick;
      logic             res_from_rec;
      status_type       res_status;
   } ctl_type;

   function automatic logic [LENGTH_W-1:0] clamp_length(input logic [LENGTH_W-1:0] len);
      if (len > LENGTH_W'(PAYLOAD_BYTES)) begin
         return LENGTH_W'(PAYLOAD_BYTES);
      end
      return len;
   endfunction

   function automatic logic [PAY_W-1:0] trim_payload(input logic [FIELD_W-1:0] data,
                                                     input logic [LENGTH_W-1:0] len);
      logic [PAY_W-1:0] res;
      res = '0;
      for (int b = 0; b < PAYLOAD_BYTES; b++) begin
         if (LENGTH_W'(b) < len) begin
            res[b*8 +: 8] = data[b*8 +: 8];
         end
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/ortp_req_if.sv =====
interface ortp_req_if;
   logic                          valid;
   logic                          ready;
   logic [ortp_pkg::OPCODE_W-1:0] opcode;
   logic [ortp_pkg::ACTION_W-1:0] action_code;
   logic [ortp_pkg::LENGTH_W-1:0] payload_length;
   logic [ortp_pkg::FIELD_W-1:0]  payload_bytes;
   logic [ortp_pkg::IDX_W-1:0]    remove_index;

   modport source (
      output valid, opcode, action_code, payload_length, payload_bytes, remove_index,
      input  ready
   );
   modport sink (
      input  valid, opcode, action_code, payload_length, payload_bytes, remove_index,
      output ready
   );
endinterface

// ===== hw/rtl/ortp_rsp_if.sv =====
interface ortp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [ortp_pkg::ACTION_W-1:0] picked_action;
   logic [ortp_pkg::LENGTH_W-1:0] picked_length;
   logic [ortp_pkg::FIELD_W-1:0]  picked_payload;
   logic                          from_recurring;

   modport source (
      output valid, status, picked_action, picked_length, picked_payload, from_recurring,
      input  ready
   );
   modport sink (
      input  valid, status, picked_action, picked_length, picked_payload, from_recurring,
      output ready
   );
endinterface

// ===== hw/rtl/oneshot_and_round_robin_task_picker.sv =====
// Task picker with an ordered one-shot list and a round-robin recurring list, each kept in
// a small memory with one write port and a registered read port. One item is in flight at
// a time and req is not ready until its response has been taken. Appends, failed requests
// and empty picks pass from acceptance through one decision step to the response; a pick
// adds a step for the registered memory read. A removal at index i closes the gap one entry
// at a time, a read and a write-back of the one-shot memory per entry, and a last compare
// step ends the walk. Lengths above the payload size are saturated and payload bytes at or
// beyond the length are cleared when an entry is stored.
module oneshot_and_round_robin_task_picker (
   input logic       clock,
   input logic       reset,
   ortp_req_if.sink   req_ch,
   ortp_rsp_if.source rsp_ch
);
   import ortp_pkg::*;

   op_type                op_ff;
   logic [IDX_W-1:0]      idx_ff;
   entry_type             item_ff;
   entry_type             item_in;

   status_type            status_ff;
   logic [ACTION_W-1:0]   act_ff;
   logic [LENGTH_W-1:0]   len_ff;
   logic [FIELD_W-1:0]    pay_ff;
   logic                  rec_ff;

   cmd_type               cmd;
   ctl_type               ctl;
   entry_type             os_rdata, rc_rdata, pick_entry, os_wdata;
   logic [ENTRY_W-1:0]    os_rbits, rc_rbits;

   always_comb begin
      item_in.action  = req_ch.action_code;
      item_in.length  = clamp_length(req_ch.payload_length);
      item_in.payload = trim_payload(req_ch.payload_bytes, clamp_length(req_ch.payload_length));
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         op_ff   <= op_type'(req_ch.opcode);
         idx_ff  <= req_ch.remove_index;
         item_ff <= item_in;
      end
   end

   assign cmd.op  = op_ff;
   assign cmd.idx = idx_ff;

   ortp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .ctl       (ctl)
   );

   assign os_wdata = ctl.os_wsel_shift ? os_rdata : item_ff;

   ortp_ram #(.DEPTH(ONESHOT_DEPTH), .WIDTH(ENTRY_W)) u_oneshot_ram (
      .clock (clock),
      .we    (ctl.os_we),
      .waddr (ctl.os_waddr),
      .wdata (os_wdata),
      .raddr (ctl.os_raddr),
      .rdata (os_rbits)
   );

   ortp_ram #(.DEPTH(RECURRING_DEPTH), .WIDTH(ENTRY_W)) u_recurring_ram (
      .clock (clock),
      .we    (ctl.rc_we),
      .waddr (ctl.rc_waddr),
      .wdata (item_ff),
      .raddr (ctl.rc_raddr),
      .rdata (rc_rbits)
   );

   assign os_rdata   = entry_type'(os_rbits);
   assign rc_rdata   = entry_type'(rc_rbits);
   assign pick_entry = ctl.res_from_rec ? rc_rdata : os_rdata;

   always_ff @(posedge clock) begin
      if (ctl.res_clear) begin
         status_ff <= ctl.res_status;
         act_ff    <= '0;
         len_ff    <= '0;
         pay_ff    <= '0;
         rec_ff    <= 1'b0;
      end else if (ctl.res_pick) begin
         status_ff <= STAT_OK;
         act_ff    <= pick_entry.action;
         len_ff    <= pick_entry.length;
         pay_ff    <= FIELD_W'(pick_entry.payload);
         rec_ff    <= ctl.res_from_rec;
      end
   end

   assign req_ch.ready          = ctl.req_ready;
   assign rsp_ch.valid          = ctl.rsp_valid;
   assign rsp_ch.status         = status_ff;
   assign rsp_ch.picked_action  = act_ff;
   assign rsp_ch.picked_length  = len_ff;
   assign rsp_ch.picked_payload = pay_ff;
   assign rsp_ch.from_recurring = rec_ff;

   a_busy_while_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("req ready while a response is pending");

   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (!req_ch.ready && !rsp_ch.valid))
      else $error("accepted item not processed before ready or response");

   a_rec_pick_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.from_recurring) |-> (rsp_ch.status == STAT_OK))
      else $error("recurring pick with non-ok status");

   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.picked_length <= LENGTH_W'(PAYLOAD_BYTES)))
      else $error("picked length above payload size");
endmodule

// ===== hw/rtl/ortp_ram.sv =====
module ortp_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== hw/rtl/ortp_ctrl.sv =====
module ortp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              rsp_ready,
   input  ortp_pkg::cmd_type cmd,
   output ortp_pkg::ctl_type ctl
);
   import ortp_pkg::*;

   state_type        st_ff, st_in;
   logic [OS_CW-1:0] os_count_ff, os_count_in;
   logic [RC_CW-1:0] rc_count_ff, rc_count_in;
   logic [RC_AW-1:0] rot_ff, rot_in;
   logic [OS_AW-1:0] ptr_ff, ptr_in;
   logic [RC_AW-1:0] sel_ff, sel_in;
   logic             src_ff, src_in;

   logic [CMP_W-1:0] cmp_lhs, cmp_rhs;
   logic             cmp_lt;
   logic [RC_AW-1:0] pick_sel;

   // single shared comparator, operands chosen by step
   always_comb begin
      cmp_lhs = '0;
      cmp_rhs = '0;
      case (st_ff)
         ST_DECIDE: begin
            case (cmd.op)
               OP_APPEND_ONESHOT: begin
                  cmp_lhs = CMP_W'(os_count_ff);
                  cmp_rhs = CMP_W'(ONESHOT_DEPTH);
               end
               OP_REMOVE_ONESHOT: begin
                  cmp_lhs = CMP_W'(cmd.idx);
                  cmp_rhs = CMP_W'(os_count_ff);
               end
               OP_APPEND_RECURRING: begin
                  cmp_lhs = CMP_W'(rc_count_ff);
                  cmp_rhs = CMP_W'(RECURRING_DEPTH);
               end
               default: begin
                  cmp_lhs = CMP_W'(rot_ff);
                  cmp_rhs = CMP_W'(rc_count_ff);
               end
            endcase
         end
         ST_SHIFT: begin
            cmp_lhs = CMP_W'(ptr_ff) + CMP_W'(1);
            cmp_rhs = CMP_W'(os_count_ff);
         end
         ST_PICK: begin
            cmp_lhs = CMP_W'(sel_ff) + CMP_W'(1);
            cmp_rhs = CMP_W'(rc_count_ff);
         end
         default: begin
            cmp_lhs = '0;
            cmp_rhs = '0;
         end
      endcase
      cmp_lt = cmp_lhs < cmp_rhs;
   end

   assign pick_sel = cmp_lt ? rot_ff : '0;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (req_valid) begin
               st_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (cmd.op)
               OP_REMOVE_ONESHOT: begin
                  st_in = cmp_lt ? ST_SHIFT : ST_RESP;
               end
               OP_PICK: begin
                  if (os_count_ff != '0 || rc_count_ff != '0) begin
                     st_in = ST_PICK;
                  end else begin
                     st_in = ST_RESP;
                  end
               end
               default: begin
                  st_in = ST_RESP;
               end
            endcase
         end
         ST_SHIFT: begin
            st_in = cmp_lt ? ST_SHIFT_WR : ST_RESP;
         end
         ST_SHIFT_WR: begin
            st_in = ST_SHIFT;
         end
         ST_PICK: begin
            st_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // outputs and counters
   always_comb begin
      ctl = '0;
      ctl.req_ready  = (st_ff == ST_IDLE);
      ctl.rsp_valid  = (st_ff == ST_RESP);
      ctl.os_raddr   = '0;
      ctl.rc_raddr   = sel_ff;
      ctl.res_status = STAT_OK;
      os_count_in    = os_count_ff;
      rc_count_in    = rc_count_ff;
      rot_in         = rot_ff;
      ptr_in         = ptr_ff;
      sel_in         = sel_ff;
      src_in         = src_ff;
      case (st_ff)
         ST_DECIDE: begin
            case (cmd.op)
               OP_APPEND_ONESHOT: begin
                  ctl.res_clear = 1'b1;
                  if (cmp_lt) begin
                     ctl.os_we    = 1'b1;
                     ctl.os_waddr = os_count_ff[OS_AW-1:0];
                     os_count_in  = os_count_ff + OS_CW'(1);
                  end else begin
                     ctl.res_status = STAT_FULL;
                  end
               end
               OP_REMOVE_ONESHOT: begin
                  if (cmp_lt) begin
                     ptr_in = cmp_lhs[OS_AW-1:0];
                  end else begin
                     ctl.res_clear  = 1'b1;
                     ctl.res_status = STAT_BAD_INDEX;
                  end
               end
               OP_APPEND_RECURRING: begin
                  ctl.res_clear = 1'b1;
                  if (cmp_lt) begin
                     ctl.rc_we    = 1'b1;
                     ctl.rc_waddr = rc_count_ff[RC_AW-1:0];
                     rc_count_in  = rc_count_ff + RC_CW'(1);
                  end else begin
                     ctl.res_status = STAT_FULL;
                  end
               end
               default: begin
                  if (os_count_ff != '0) begin
                     src_in = 1'b0;
                  end else if (rc_count_ff != '0) begin
                     src_in       = 1'b1;
                     sel_in       = pick_sel;
                     ctl.rc_raddr = pick_sel;
                  end else begin
                     ctl.res_clear  = 1'b1;
                     ctl.res_status = STAT_EMPTY;
                  end
               end
            endcase
         end
         ST_SHIFT: begin
            ctl.os_raddr = cmp_lhs[OS_AW-1:0];
            if (!cmp_lt) begin
               os_count_in   = os_count_ff - OS_CW'(1);
               ctl.res_clear = 1'b1;
            end
         end
         ST_SHIFT_WR: begin
            ctl.os_we         = 1'b1;
            ctl.os_waddr      = ptr_ff;
            ctl.os_wsel_shift = 1'b1;
            ptr_in            = ptr_ff + OS_AW'(1);
         end
         ST_PICK: begin
            ctl.res_pick     = 1'b1;
            ctl.res_from_rec = src_ff;
            if (src_ff) begin
               rot_in = cmp_lt ? cmp_lhs[RC_AW-1:0] : '0;
            end
         end
         default: begin
            ctl.res_clear = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         os_count_ff <= '0;
         rc_count_ff <= '0;
         rot_ff      <= '0;
      end else begin
         st_ff       <= st_in;
         os_count_ff <= os_count_in;
         rc_count_ff <= rc_count_in;
         rot_ff      <= rot_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      sel_ff <= sel_in;
      src_ff <= src_in;
   end
endmodule
